// ===== hdl/aebp_pkg.sv =====
// Shared types and constants for the ADC event block parser.
package aebp_pkg;

  // Word type field, bits 24-26 of a readout word.
  localparam logic [2:0] TYPE_DATA   = 3'd0;
  localparam logic [2:0] TYPE_HEADER = 3'd2;
  localparam logic [2:0] TYPE_END    = 3'd4;

  // Classified word type carried from the front to the back.
  localparam logic [1:0] WT_DATA   = 2'd0;
  localparam logic [1:0] WT_HEADER = 2'd1;
  localparam logic [1:0] WT_END    = 2'd2;
  localparam logic [1:0] WT_OTHER  = 2'd3;

  // Result kinds.
  localparam logic [2:0] KIND_HDR_OK   = 3'd0;
  localparam logic [2:0] KIND_DATA     = 3'd1;
  localparam logic [2:0] KIND_END_OK   = 3'd2;
  localparam logic [2:0] KIND_BAD_HDR  = 3'd3;
  localparam logic [2:0] KIND_BAD_DATA = 3'd4;
  localparam logic [2:0] KIND_BAD_END  = 3'd5;

  // Queue between front and back.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // One classified request with the word fields already unpacked.
  typedef struct packed {
    logic [1:0]  wtype;
    logic [4:0]  geo;
    logic [7:0]  crate;
    logic [5:0]  count;
    logic [11:0] value;
    logic        over;
    logic        under;
    logic [4:0]  chan;
  } item_t;

  // One result request.
  typedef struct packed {
    logic [2:0]  kind;
    logic [11:0] conv_value;
    logic        over_flag;
    logic        under_flag;
    logic [4:0]  chan_num;
    logic [4:0]  geo_addr;
    logic [7:0]  crate_num;
    logic [5:0]  chan_count;
  } result_t;

endpackage

// ===== hdl/adc_event_block_parser_unit.sv =====
// Top level of the ADC event block parser: front, queue and back joined.
//
//   Channel   Direction  Handshake     Payload
//   input     in         push / full   word[31:0]
//   result    out        pop / empty   kind, conv_value, over_flag, under_flag,
//                                      chan_num, geo_addr, crate_num, chan_count
//
// Every accepted word yields exactly one result, in order. The block sustains
// one word per cycle while results are popped: the front register, the
// four-entry queue and the result register each move one request a cycle. A
// word passes the front register, queue and result register in turn. Reset is
// synchronous and clears the framing state, the queue and all valid flags.
// When pop is held low, the result register keeps its request, the queue
// fills and full rises once the front register is also occupied.
module adc_event_block_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [31:0] word,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  kind,
  output logic [11:0] conv_value,
  output logic        over_flag,
  output logic        under_flag,
  output logic [4:0]  chan_num,
  output logic [4:0]  geo_addr,
  output logic [7:0]  crate_num,
  output logic [5:0]  chan_count
);

  // Classified request leaving the front register.
  logic              front_valid;
  logic              front_ready;
  aebp_pkg::item_t   front_item;

  // Head of the queue feeding the back.
  logic              back_valid;
  logic              back_ready;
  aebp_pkg::item_t   back_item;

  // Result register.
  logic              res_valid;
  aebp_pkg::result_t res;

  // The front decodes bits 24-26 and unpacks every field a request may need.
  aebp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .word       (word),
    .item_valid (front_valid),
    .item_ready (front_ready),
    .item       (front_item)
  );

  // The queue lets the front keep taking words while the back is held up.
  aebp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_item  (front_item),
    .rd_valid (back_valid),
    .rd_ready (back_ready),
    .rd_item  (back_item)
  );

  // The back tracks header, data and end framing and builds each result.
  aebp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (back_valid),
    .item_ready (back_ready),
    .item       (back_item),
    .res_valid  (res_valid),
    .res_pop    (pop),
    .res        (res)
  );

  assign empty      = !res_valid;
  assign kind       = res.kind;
  assign conv_value = res.conv_value;
  assign over_flag  = res.over_flag;
  assign under_flag = res.under_flag;
  assign chan_num   = res.chan_num;
  assign geo_addr   = res.geo_addr;
  assign crate_num  = res.crate_num;
  assign chan_count = res.chan_count;

endmodule

// ===== hdl/aebp_front.sv =====
// Front stage: accepts readout words, classifies and unpacks them.
module aebp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [31:0]         word,
  output logic                item_valid,
  input  logic                item_ready,
  output aebp_pkg::item_t     item
);

  logic            held_valid;
  aebp_pkg::item_t held;
  aebp_pkg::item_t cls;
  logic            take;

  always_comb begin
    cls.geo   = word[31:27];
    cls.crate = word[23:16];
    cls.count = word[13:8];
    cls.value = word[11:0];
    cls.over  = word[12];
    cls.under = word[13];
    cls.chan  = word[20:16];
    unique case (word[26:24])
      aebp_pkg::TYPE_DATA:   cls.wtype = aebp_pkg::WT_DATA;
      aebp_pkg::TYPE_HEADER: cls.wtype = aebp_pkg::WT_HEADER;
      aebp_pkg::TYPE_END:    cls.wtype = aebp_pkg::WT_END;
      default:               cls.wtype = aebp_pkg::WT_OTHER;
    endcase
  end

  assign full = held_valid && !item_ready;
  assign take = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (take) begin
      held_valid <= 1'b1;
    end else if (item_ready) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held <= cls;
    end
  end

  assign item_valid = held_valid;
  assign item       = held;

endmodule

// ===== hdl/aebp_queue.sv =====
// Short queue of classified requests between the front and the back.
module aebp_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_valid,
  output logic                wr_ready,
  input  aebp_pkg::item_t     wr_item,
  output logic                rd_valid,
  input  logic                rd_ready,
  output aebp_pkg::item_t     rd_item
);

  aebp_pkg::item_t            slots [aebp_pkg::Q_DEPTH];
  logic [aebp_pkg::Q_AW-1:0]  wr_ptr;
  logic [aebp_pkg::Q_AW-1:0]  rd_ptr;
  logic [aebp_pkg::Q_AW:0]    count;
  logic                       do_wr;
  logic                       do_rd;

  assign wr_ready = (count != (aebp_pkg::Q_AW+1)'(aebp_pkg::Q_DEPTH));
  assign rd_valid = (count != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_item;
    end
  end

endmodule

// ===== hdl/aebp_back.sv =====
// Back stage: framing state machine and the result register.
module aebp_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  aebp_pkg::item_t     item,
  output logic                res_valid,
  input  logic                res_pop,
  output aebp_pkg::result_t   res
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_DATA   = 2'd1;
  localparam logic [1:0] PH_END    = 2'd2;

  logic [1:0] phase;
  logic [1:0] phase_next;
  logic [5:0] words_left;
  logic [5:0] words_left_next;
  logic [5:0] words_dec;
  logic [4:0] held_geo;
  logic [4:0] held_geo_next;
  logic [7:0] held_crate;
  logic [7:0] held_crate_next;
  logic [5:0] held_count;
  logic [5:0] held_count_next;
  logic       load;
  aebp_pkg::result_t res_next;

  assign item_ready = !res_valid || res_pop;
  assign load       = item_valid && item_ready;
  assign words_dec  = words_left - 6'd1;

  always_comb begin
    phase_next      = phase;
    words_left_next = words_left;
    held_geo_next   = held_geo;
    held_crate_next = held_crate;
    held_count_next = held_count;
    res_next        = '0;
    unique case (phase)
      PH_DATA: begin
        if (item.wtype == aebp_pkg::WT_DATA) begin
          res_next.kind       = aebp_pkg::KIND_DATA;
          res_next.conv_value = item.value;
          res_next.over_flag  = item.over;
          res_next.under_flag = item.under;
          res_next.chan_num   = item.chan;
          words_left_next     = words_dec;
          if (words_dec == 6'd0) begin
            phase_next = PH_END;
          end
        end else begin
          res_next.kind   = aebp_pkg::KIND_BAD_DATA;
          phase_next      = PH_HEADER;
          words_left_next = 6'd0;
        end
      end
      PH_END: begin
        res_next.kind   = (item.wtype == aebp_pkg::WT_END) ?
                          aebp_pkg::KIND_END_OK : aebp_pkg::KIND_BAD_END;
        phase_next      = PH_HEADER;
        words_left_next = 6'd0;
      end
      default: begin
        // Expecting a header; the unused phase code behaves the same way.
        if (item.wtype == aebp_pkg::WT_HEADER) begin
          res_next.kind   = aebp_pkg::KIND_HDR_OK;
          held_geo_next   = item.geo;
          held_crate_next = item.crate;
          held_count_next = item.count;
          words_left_next = item.count;
          phase_next      = (item.count == 6'd0) ? PH_END : PH_DATA;
        end else begin
          res_next.kind = aebp_pkg::KIND_BAD_HDR;
          phase_next    = PH_HEADER;
        end
      end
    endcase
    res_next.geo_addr   = held_geo_next;
    res_next.crate_num  = held_crate_next;
    res_next.chan_count = held_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      words_left <= 6'd0;
      held_geo   <= 5'd0;
      held_crate <= 8'd0;
      held_count <= 6'd0;
      res_valid  <= 1'b0;
    end else begin
      if (load) begin
        phase      <= phase_next;
        words_left <= words_left_next;
        held_geo   <= held_geo_next;
        held_crate <= held_crate_next;
        held_count <= held_count_next;
        res_valid  <= 1'b1;
      end else if (res_pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_next;
    end
  end

endmodule

// ===== hdl/aebp_checker.sv =====
// Port-level checker for the ADC event block parser, bound to the top level.
module aebp_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [2:0]  kind,
  input logic [11:0] conv_value,
  input logic        over_flag,
  input logic        under_flag,
  input logic [4:0]  chan_num,
  input logic [4:0]  geo_addr
);

  // Reset leaves no result waiting.
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  // Reset leaves the input side ready for a request.
  a_reset_not_full: assert property (@(posedge clk) rst |=> !full)
    else $error("input full after reset");

  // Only defined result kinds appear.
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (kind <= aebp_pkg::KIND_BAD_END))
    else $error("undefined result kind");

  // Data fields are zero on every result that is not channel data.
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind != aebp_pkg::KIND_DATA) |->
      (conv_value == 12'd0 && !over_flag && !under_flag && chan_num == 5'd0))
    else $error("data fields set on a non-data result");

  // A result not taken stays on the ports unchanged.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(kind) && $stable(geo_addr)))
    else $error("waiting result changed");

endmodule

bind adc_event_block_parser_unit aebp_checker u_aebp_checker (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .empty      (empty),
  .pop        (pop),
  .kind       (kind),
  .conv_value (conv_value),
  .over_flag  (over_flag),
  .under_flag (under_flag),
  .chan_num   (chan_num),
  .geo_addr   (geo_addr)
);
